>>> hw/rtl/tss_pkg.sv
// shared types, command codes and constants of the transmission shift sequencer
// no dependencies; used by every module of the block
`default_nettype none

package tss_pkg;

   // field widths
   localparam int OP_W    = 2;
   localparam int KEY_W   = 3;
   localparam int GEAR_W  = 8;
   localparam int LED_W   = 8;
   localparam int PRESS_W = 3;
   localparam int SPEED_W = 2;
   localparam int DELAY_W = 16;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_GEAR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT_DELAY  = 1'd1;

   // register reset values
   localparam logic [GEAR_W-1:0]  INITIAL_GEAR_RESET = 8'h00;
   localparam logic [DELAY_W-1:0] SHIFT_DELAY_RESET  = 16'd150;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // operation codes on the request channel
   localparam logic [OP_W-1:0] OP_KEY  = 2'd0;
   localparam logic [OP_W-1:0] OP_PASS = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK = 2'd2;

   // key numbers
   localparam logic [KEY_W-1:0] KEY_AUTO     = 3'd7;
   localparam logic [KEY_W-1:0] KEY_HOLD2    = 3'd6;
   localparam logic [KEY_W-1:0] KEY_HOLD1    = 3'd5;
   localparam logic [KEY_W-1:0] KEY_SPEED    = 3'd2;
   localparam logic [KEY_W-1:0] KEY_PRESSURE = 3'd1;

   // classified commands carried through the queue
   localparam int CMD_W = 3;
   localparam logic [CMD_W-1:0] CMD_NOP      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_AUTO     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_HOLD2    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_HOLD1    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SPEED    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_PRESSURE = 3'd5;
   localparam logic [CMD_W-1:0] CMD_PASS     = 3'd6;
   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd7;

   // gear coding
   localparam logic [GEAR_W-1:0] GEAR_DIR_MASK = 8'hF0;
   localparam logic [GEAR_W-1:0] GEAR_NUM_MASK = 8'h0F;
   localparam logic [GEAR_W-1:0] GEAR_FIRST    = 8'h01;

   // indicator bits
   localparam logic [LED_W-1:0] LED_POWER = 8'h01;
   localparam logic [LED_W-1:0] LED_HOLD1 = 8'h20;
   localparam logic [LED_W-1:0] LED_HOLD2 = 8'h40;
   localparam logic [LED_W-1:0] LED_AUTO  = 8'h80;

   // channel ranges
   localparam logic [SPEED_W-1:0] SPEED_TOP = 2'd3;
   localparam logic [PRESS_W-1:0] PRESS_TOP = 3'd6;

   // one queued command
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [GEAR_W-1:0] selector;
      logic [GEAR_W-1:0] goal_auto;
      logic              change;
   } tss_item_type;

   // one result transaction
   typedef struct packed {
      logic [GEAR_W-1:0]  process_gear;
      logic [GEAR_W-1:0]  goal_gear;
      logic               valve_update;
      logic [LED_W-1:0]   led_byte;
      logic               led_write;
      logic               auto_mode;
      logic [PRESS_W-1:0] pressure_channel;
      logic [SPEED_W-1:0] speed_channel;
   } tss_result_type;

   // queue occupancy as seen by the top level
   typedef struct packed {
      logic empty;
      logic full;
   } tss_queue_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/tss_front.sv
// front end: classifies request transactions into queue commands
// depends on tss_pkg
`default_nettype none

module tss_front (
   input  wire logic [tss_pkg::OP_W-1:0]   op,
   input  wire logic [tss_pkg::KEY_W-1:0]  key,
   input  wire logic [tss_pkg::GEAR_W-1:0] selector,
   input  wire logic                       kickdown,
   input  wire logic                       change,
   output tss_pkg::tss_item_type           item
);

   logic [tss_pkg::CMD_W-1:0] key_cmd;

   // key number to command
   always_comb begin
      unique case (key)
         tss_pkg::KEY_AUTO:     key_cmd = tss_pkg::CMD_AUTO;
         tss_pkg::KEY_HOLD2:    key_cmd = tss_pkg::CMD_HOLD2;
         tss_pkg::KEY_HOLD1:    key_cmd = tss_pkg::CMD_HOLD1;
         tss_pkg::KEY_SPEED:    key_cmd = tss_pkg::CMD_SPEED;
         tss_pkg::KEY_PRESSURE: key_cmd = tss_pkg::CMD_PRESSURE;
         default:               key_cmd = tss_pkg::CMD_NOP;
      endcase
   end

   // operation to command, kickdown goal worked out ahead of the back end
   always_comb begin
      item.selector  = selector;
      item.goal_auto = kickdown ? ((selector & tss_pkg::GEAR_DIR_MASK) | tss_pkg::GEAR_FIRST)
                                : selector;
      item.change    = change;
      unique case (op)
         tss_pkg::OP_KEY:  item.cmd = key_cmd;
         tss_pkg::OP_PASS: item.cmd = tss_pkg::CMD_PASS;
         tss_pkg::OP_TICK: item.cmd = tss_pkg::CMD_TICK;
         default:          item.cmd = tss_pkg::CMD_NOP;
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/tss_queue.sv
// short command queue between front and back end
// depends on tss_pkg
`default_nettype none

module tss_queue #(
   parameter int DEPTH = tss_pkg::QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire tss_pkg::tss_item_type  push_item,
   input  wire logic                   pop,
   output tss_pkg::tss_item_type       head_item,
   output tss_pkg::tss_queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   tss_pkg::tss_item_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);

endmodule

`default_nettype wire

>>> hw/rtl/tss_back.sv
// back end: sequencer state, configuration registers and result register
// depends on tss_pkg
`default_nettype none

module tss_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             item_valid,
   input  wire tss_pkg::tss_item_type            item,
   output logic                                  item_ready,
   input  wire logic                             cfg_write,
   input  wire logic [tss_pkg::CSR_INDEX_W-1:0]  cfg_index,
   input  wire logic [tss_pkg::CSR_DATA_W-1:0]   cfg_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output tss_pkg::tss_result_type               rsp
);

   logic [tss_pkg::DELAY_W-1:0] shift_delay_ff, shift_delay_in;
   logic                        auto_ff, auto_in;
   logic                        hold1_ff, hold1_in;
   logic                        hold2_ff, hold2_in;
   logic [tss_pkg::LED_W-1:0]   led_ff, led_in;
   logic [tss_pkg::GEAR_W-1:0]  process_ff, process_in;
   logic [tss_pkg::GEAR_W-1:0]  goal_ff, goal_in;
   logic [tss_pkg::PRESS_W-1:0] press_ff, press_in;
   logic [tss_pkg::SPEED_W-1:0] speed_ff, speed_in;
   logic [tss_pkg::DELAY_W-1:0] delay_ff, delay_in;
   logic                        pending_ff, pending_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   tss_pkg::tss_result_type     rsp_ff, rsp_in;

   logic                        take;
   logic                        valve;
   logic                        led_wr;
   logic                        step;
   logic [3:0]                  cur_num;
   logic [3:0]                  goal_num;

   // a register write holds the queued command back for that cycle
   assign item_ready = (!rsp_valid_ff || rsp_ready) && !cfg_write;
   assign take       = item_valid && item_ready;

   // gear step toward the goal
   assign cur_num  = process_ff[3:0];
   assign goal_num = item.goal_auto[3:0];
   assign step     = (process_ff != item.goal_auto) && (delay_ff == '0);

   // state update for one configuration write or one command
   always_comb begin
      shift_delay_in = shift_delay_ff;
      auto_in        = auto_ff;
      hold1_in       = hold1_ff;
      hold2_in       = hold2_ff;
      led_in         = led_ff;
      process_in     = process_ff;
      goal_in        = goal_ff;
      press_in       = press_ff;
      speed_in       = speed_ff;
      delay_in       = delay_ff;
      pending_in     = pending_ff;
      valve          = 1'b0;
      led_wr         = 1'b0;
      if (cfg_write) begin
         case (cfg_index)
            tss_pkg::CSR_INITIAL_GEAR: begin
               process_in = cfg_data[tss_pkg::GEAR_W-1:0];
               goal_in    = cfg_data[tss_pkg::GEAR_W-1:0];
            end
            tss_pkg::CSR_SHIFT_DELAY: shift_delay_in = cfg_data[tss_pkg::DELAY_W-1:0];
            default: ;
         endcase
      end else if (take) begin
         unique case (item.cmd)
            tss_pkg::CMD_AUTO: begin
               led_wr = 1'b1;
               if (!auto_ff) begin
                  auto_in = 1'b1;
                  led_in  = led_ff | tss_pkg::LED_AUTO;
               end else begin
                  auto_in  = 1'b0;
                  hold1_in = 1'b0;
                  hold2_in = 1'b0;
                  led_in   = led_ff & ~(tss_pkg::LED_AUTO | tss_pkg::LED_HOLD1
                                        | tss_pkg::LED_HOLD2);
               end
            end
            tss_pkg::CMD_HOLD2: begin
               if (auto_ff) begin
                  led_wr = 1'b1;
                  if (!hold2_ff) begin
                     hold2_in = 1'b1;
                     hold1_in = 1'b0;
                     led_in   = (led_ff & ~tss_pkg::LED_HOLD1) | tss_pkg::LED_HOLD2;
                  end else begin
                     hold2_in = 1'b0;
                     led_in   = led_ff & ~tss_pkg::LED_HOLD2;
                  end
               end
            end
            tss_pkg::CMD_HOLD1: begin
               if (auto_ff) begin
                  led_wr = 1'b1;
                  if (!hold1_ff) begin
                     hold1_in = 1'b1;
                     hold2_in = 1'b0;
                     led_in   = (led_ff & ~tss_pkg::LED_HOLD2) | tss_pkg::LED_HOLD1;
                  end else begin
                     hold1_in = 1'b0;
                     led_in   = led_ff & ~tss_pkg::LED_HOLD1;
                  end
               end
            end
            tss_pkg::CMD_SPEED: begin
               speed_in = (speed_ff >= tss_pkg::SPEED_TOP) ? tss_pkg::SPEED_W'(1)
                                                           : speed_ff + 1'b1;
            end
            tss_pkg::CMD_PRESSURE: begin
               press_in = (press_ff >= tss_pkg::PRESS_TOP) ? tss_pkg::PRESS_W'(1)
                                                           : press_ff + 1'b1;
            end
            tss_pkg::CMD_PASS: begin
               // a stepping pass always rewrites the valves; every pass clears pending
               if (auto_ff) begin
                  goal_in = item.goal_auto;
                  if (step) begin
                     if ((process_ff & tss_pkg::GEAR_DIR_MASK)
                         != (item.goal_auto & tss_pkg::GEAR_DIR_MASK)) begin
                        process_in = (item.goal_auto & tss_pkg::GEAR_DIR_MASK)
                                     | tss_pkg::GEAR_FIRST;
                     end else if (cur_num < goal_num) begin
                        process_in = process_ff + 1'b1;
                     end else if (cur_num > goal_num) begin
                        process_in = process_ff - 1'b1;
                     end
                     delay_in = shift_delay_ff;
                  end
               end else begin
                  goal_in    = item.selector;
                  process_in = item.selector;
               end
               valve      = pending_ff || item.change || (auto_ff && step);
               pending_in = 1'b0;
            end
            tss_pkg::CMD_TICK: begin
               if (delay_ff != '0) begin
                  delay_in = delay_ff - 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // result register, loaded with the state after the command
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (take) begin
         rsp_valid_in            = 1'b1;
         rsp_in.process_gear     = process_in;
         rsp_in.goal_gear        = goal_in;
         rsp_in.valve_update     = valve;
         rsp_in.led_byte         = led_in;
         rsp_in.led_write        = led_wr;
         rsp_in.auto_mode        = auto_in;
         rsp_in.pressure_channel = press_in;
         rsp_in.speed_channel    = speed_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_delay_ff <= tss_pkg::SHIFT_DELAY_RESET;
         auto_ff        <= 1'b0;
         hold1_ff       <= 1'b0;
         hold2_ff       <= 1'b0;
         led_ff         <= tss_pkg::LED_POWER;
         process_ff     <= tss_pkg::INITIAL_GEAR_RESET;
         goal_ff        <= tss_pkg::INITIAL_GEAR_RESET;
         press_ff       <= tss_pkg::PRESS_W'(1);
         speed_ff       <= tss_pkg::SPEED_W'(1);
         delay_ff       <= '0;
         pending_ff     <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         shift_delay_ff <= shift_delay_in;
         auto_ff        <= auto_in;
         hold1_ff       <= hold1_in;
         hold2_ff       <= hold2_in;
         led_ff         <= led_in;
         process_ff     <= process_in;
         goal_ff        <= goal_in;
         press_ff       <= press_in;
         speed_ff       <= speed_in;
         delay_ff       <= delay_in;
         pending_ff     <= pending_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

>>> hw/rtl/transmission_shift_sequencer.sv
// a request passes through a queue slot, then the result register, to its response
// throughput: one transaction per cycle while responses are accepted and no
// configuration write is taken; the two-entry queue lets new requests in while
// a result waits. configuration writes are taken every cycle.
// reset: synchronous, active high; manual mode, power lamp on, gears at the
// initial gear reset value, channels at one, delay idle, valve update pending
`default_nettype none

module transmission_shift_sequencer #(
   parameter int QUEUE_DEPTH = tss_pkg::QUEUE_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [tss_pkg::OP_W-1:0]         req_operation,
   input  wire logic [tss_pkg::KEY_W-1:0]        req_key_code,
   input  wire logic [tss_pkg::GEAR_W-1:0]       req_selector_gear,
   input  wire logic                             req_kickdown,
   input  wire logic                             req_change_request,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [tss_pkg::GEAR_W-1:0]            rsp_process_gear,
   output logic [tss_pkg::GEAR_W-1:0]            rsp_goal_gear,
   output logic                                  rsp_valve_update,
   output logic [tss_pkg::LED_W-1:0]             rsp_led_byte,
   output logic                                  rsp_led_write,
   output logic                                  rsp_auto_mode,
   output logic [tss_pkg::PRESS_W-1:0]           rsp_pressure_channel,
   output logic [tss_pkg::SPEED_W-1:0]           rsp_speed_channel,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [tss_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tss_pkg::CSR_DATA_W-1:0]   csr_data
);

   tss_pkg::tss_item_type         front_item;
   tss_pkg::tss_item_type         head_item;
   tss_pkg::tss_queue_status_type queue_status;
   tss_pkg::tss_result_type       rsp;
   logic                          push;
   logic                          pop;
   logic                          back_ready;

   assign req_ready = !queue_status.full;
   assign push      = req_valid && req_ready;
   assign pop       = !queue_status.empty && back_ready;
   assign csr_ready = 1'b1;

   // classify incoming transactions
   tss_front u_front (
      .op       (req_operation),
      .key      (req_key_code),
      .selector (req_selector_gear),
      .kickdown (req_kickdown),
      .change   (req_change_request),
      .item     (front_item)
   );

   // decoupling queue
   tss_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (queue_status)
   );

   // sequencer state and results
   tss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!queue_status.empty),
      .item       (head_item),
      .item_ready (back_ready),
      .cfg_write  (csr_valid && csr_ready),
      .cfg_index  (csr_index),
      .cfg_data   (csr_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   assign rsp_process_gear     = rsp.process_gear;
   assign rsp_goal_gear        = rsp.goal_gear;
   assign rsp_valve_update     = rsp.valve_update;
   assign rsp_led_byte         = rsp.led_byte;
   assign rsp_led_write        = rsp.led_write;
   assign rsp_auto_mode        = rsp.auto_mode;
   assign rsp_pressure_channel = rsp.pressure_channel;
   assign rsp_speed_channel    = rsp.speed_channel;

   // a pushed transaction is waiting in the queue on the next cycle
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push |=> !queue_status.empty)
      else $error("queue empty after push");

   // queue can never be full and empty together
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(queue_status.full && queue_status.empty))
      else $error("queue status inconsistent");

   // a key result and a valve result never come from the same transaction
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_valve_update && rsp_led_write))
      else $error("valve update and led write together");

   // hold lamps are exclusive and only lit in auto mode
   a_hold_lamps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!(rsp_led_byte[5] && rsp_led_byte[6])
                     && (!(rsp_led_byte[5] || rsp_led_byte[6]) || rsp_led_byte[7])))
      else $error("hold lamps inconsistent");

endmodule

`default_nettype wire
